>>> rtl/chat_message_deframer_top_assert.svh
// assertion macros used by the deframer top
`ifndef CHAT_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define CHAT_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define CMD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define CMD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

>>> rtl/cmd_pkg.sv
package cmd_pkg;

   localparam int BUFFER_BYTES  = 1024;
   localparam int TYPE_LIMIT    = 31;
   localparam int NAME_LIMIT    = 31;
   localparam int ADDRESS_LIMIT = 15;

   // counters hold up to BUFFER_BYTES-1 and must also compare against the 8-bit limits
   localparam int CNT_W = ($clog2(BUFFER_BYTES) > 8) ? $clog2(BUFFER_BYTES) : 8;

   localparam logic [CNT_W-1:0] BUF_MAX   = CNT_W'(BUFFER_BYTES - 1);
   localparam logic [CNT_W-1:0] TYPE_MAX  = CNT_W'(TYPE_LIMIT);
   localparam logic [CNT_W-1:0] NAME_MAX  = CNT_W'(NAME_LIMIT);
   localparam logic [CNT_W-1:0] ADDR_MAX  = CNT_W'(ADDRESS_LIMIT);

   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   // bytes seen saturate here; fewer than this is a short message
   localparam logic [2:0] HDR_FULL  = 3'd7;
   localparam logic [2:0] MAGIC_END = 3'd3;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_TYPE_SKIP,
      PH_TYPE,
      PH_SENDER_SKIP,
      PH_SENDER,
      PH_CONTENT
   } phase_type;

   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_TYPE,
      TAG_NAME,
      TAG_ADDR,
      TAG_CONTENT
   } tag_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_MAGIC,
      ST_NO_TYPE,
      ST_NO_SENDER
   } status_type;

   typedef struct packed {
      tag_type    tag;
      logic [7:0] data;
      logic       eom;
      status_type status;
      logic       addr_unknown;
   } res_type;

endpackage

>>> rtl/cmd_parser.sv
module cmd_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data,
   input  logic [7:0]      in_byte,
   input  logic            in_last,
   input  logic            advance,
   output logic            has_result,
   output cmd_pkg::res_type result
);
   import cmd_pkg::*;

   logic [31:0]      magic_ff;
   phase_type        phase_ff, phase_in, phase_nx;
   logic [2:0]       hdr_cnt_ff, hdr_cnt_in, hdr_cnt_nx;
   logic             magic_ok_ff, magic_ok_in, magic_ok_nx;
   logic [CNT_W-1:0] field_cnt_ff, field_cnt_in;
   logic [CNT_W-1:0] sender_cnt_ff, sender_cnt_in;
   logic             at_found_ff, at_found_in, at_found_nx;
   logic             text_ended_ff, text_ended_in;

   logic             is_pipe, is_nul, is_at;
   logic             active;
   logic             sender_byte;
   logic [CNT_W-1:0] snd_cnt_eff;
   logic             at_eff;
   logic             snd_room;
   logic [7:0]       magic_sel;
   tag_type          tag;
   status_type       status;

   assign is_pipe = (in_byte == CHAR_PIPE);
   assign is_nul  = (in_byte == CHAR_NUL);
   assign is_at   = (in_byte == CHAR_AT);
   assign active  = (phase_ff != PH_MAGIC) && !text_ended_ff && !is_nul;

   // the first sender byte starts a fresh sender
   assign sender_byte = active && !is_pipe &&
                        ((phase_ff == PH_SENDER_SKIP) || (phase_ff == PH_SENDER));
   assign snd_cnt_eff = (phase_ff == PH_SENDER_SKIP) ? '0 : sender_cnt_ff;
   assign at_eff      = (phase_ff == PH_SENDER_SKIP) ? 1'b0 : at_found_ff;
   assign snd_room    = (snd_cnt_eff < BUF_MAX);

   always_comb begin
      case (hdr_cnt_ff[1:0])
         2'd0:    magic_sel = magic_ff[31:24];
         2'd1:    magic_sel = magic_ff[23:16];
         2'd2:    magic_sel = magic_ff[15:8];
         default: magic_sel = magic_ff[7:0];
      endcase
   end

   // next state
   always_comb begin
      phase_nx      = phase_ff;
      magic_ok_nx   = magic_ok_ff;
      at_found_nx   = at_found_ff;
      field_cnt_in  = field_cnt_ff;
      sender_cnt_in = sender_cnt_ff;
      text_ended_in = text_ended_ff;
      hdr_cnt_nx    = (hdr_cnt_ff == HDR_FULL) ? HDR_FULL : hdr_cnt_ff + 3'd1;

      if (phase_ff == PH_MAGIC) begin
         if (magic_sel != in_byte) begin
            magic_ok_nx = 1'b0;
         end
         if (hdr_cnt_ff >= MAGIC_END) begin
            phase_nx = PH_TYPE_SKIP;
         end
      end else if (!text_ended_ff && is_nul) begin
         text_ended_in = 1'b1;
      end else if (active) begin
         case (phase_ff)
            PH_TYPE_SKIP: begin
               if (!is_pipe) begin
                  phase_nx     = PH_TYPE;
                  field_cnt_in = CNT_W'(1);
               end
            end
            PH_TYPE: begin
               if (is_pipe) begin
                  phase_nx = PH_SENDER_SKIP;
               end else if (field_cnt_ff < TYPE_MAX) begin
                  field_cnt_in = field_cnt_ff + CNT_W'(1);
               end
            end
            PH_SENDER_SKIP, PH_SENDER: begin
               if (is_pipe && phase_ff == PH_SENDER) begin
                  phase_nx     = PH_CONTENT;
                  field_cnt_in = '0;
               end else if (!is_pipe) begin
                  phase_nx      = PH_SENDER;
                  sender_cnt_in = snd_cnt_eff;
                  at_found_nx   = at_eff;
                  if (snd_room) begin
                     if (!at_eff && is_at) begin
                        at_found_nx  = 1'b1;
                        field_cnt_in = '0;
                     end else if (at_eff && field_cnt_ff < ADDR_MAX) begin
                        field_cnt_in = field_cnt_ff + CNT_W'(1);
                     end
                     sender_cnt_in = snd_cnt_eff + CNT_W'(1);
                  end
               end
            end
            default: begin
               if (field_cnt_ff < BUF_MAX) begin
                  field_cnt_in = field_cnt_ff + CNT_W'(1);
               end
            end
         endcase
      end

      phase_in    = phase_nx;
      hdr_cnt_in  = hdr_cnt_nx;
      magic_ok_in = magic_ok_nx;
      at_found_in = at_found_nx;
      if (in_last) begin
         phase_in      = PH_MAGIC;
         hdr_cnt_in    = '0;
         magic_ok_in   = 1'b1;
         at_found_in   = 1'b0;
         field_cnt_in  = '0;
         sender_cnt_in = '0;
         text_ended_in = 1'b0;
      end
   end

   // outputs
   always_comb begin
      tag = TAG_NONE;
      if (active) begin
         case (phase_ff)
            PH_TYPE_SKIP: begin
               if (!is_pipe) begin
                  tag = TAG_TYPE;
               end
            end
            PH_TYPE: begin
               if (!is_pipe && field_cnt_ff < TYPE_MAX) begin
                  tag = TAG_TYPE;
               end
            end
            PH_SENDER_SKIP, PH_SENDER: begin
               if (sender_byte && snd_room) begin
                  if (!at_eff && !is_at && snd_cnt_eff < NAME_MAX) begin
                     tag = TAG_NAME;
                  end else if (at_eff && field_cnt_ff < ADDR_MAX) begin
                     tag = TAG_ADDR;
                  end
               end
            end
            PH_CONTENT: begin
               if (field_cnt_ff < BUF_MAX) begin
                  tag = TAG_CONTENT;
               end
            end
            default: tag = TAG_NONE;
         endcase
      end

      status = ST_OK;
      if (in_last) begin
         if (hdr_cnt_nx < HDR_FULL) begin
            status = ST_SHORT;
         end else if (!magic_ok_nx) begin
            status = ST_MAGIC;
         end else if (phase_nx == PH_MAGIC || phase_nx == PH_TYPE_SKIP) begin
            status = ST_NO_TYPE;
         end else if (phase_nx == PH_TYPE || phase_nx == PH_SENDER_SKIP) begin
            status = ST_NO_SENDER;
         end
      end

      has_result          = (tag != TAG_NONE) || in_last;
      result.tag          = tag;
      result.data         = (tag == TAG_NONE) ? CHAR_NUL : in_byte;
      result.eom          = in_last;
      result.status       = status;
      result.addr_unknown = in_last && (status == ST_OK) && !at_found_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff      <= '0;
         phase_ff      <= PH_MAGIC;
         hdr_cnt_ff    <= '0;
         magic_ok_ff   <= 1'b1;
         field_cnt_ff  <= '0;
         sender_cnt_ff <= '0;
         at_found_ff   <= 1'b0;
         text_ended_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            magic_ff <= csr_write_data;
         end
         if (advance) begin
            phase_ff      <= phase_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            magic_ok_ff   <= magic_ok_in;
            field_cnt_ff  <= field_cnt_in;
            sender_cnt_ff <= sender_cnt_in;
            at_found_ff   <= at_found_in;
            text_ended_ff <= text_ended_in;
         end
      end
   end

endmodule

>>> rtl/cmd_out_reg.sv
module cmd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cmd_pkg::res_type res_in,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic             slot_free,
   output cmd_pkg::res_type res_out
);
   import cmd_pkg::*;

   logic    valid_ff, valid_in;
   res_type res_ff;

   // slot frees in the same cycle the waiting result is taken
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign res_out   = res_ff;

endmodule

>>> rtl/chat_message_deframer_top.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_data_byte, req_last_byte
// rsp       out        rsp_valid / rsp_stall  rsp_field_tag, rsp_out_byte,
//                                             rsp_end_of_message, rsp_status,
//                                             rsp_address_unknown
// csr       in         csr_write_enable       csr_write_data (magic word)
//
// one byte per cycle unless stalled; results pass the input then the output register
// bytes that give no result pass through without needing the output slot
// reset is synchronous and returns the parser to the magic phase, magic word 0
// a stalled output holds its result while the input register takes one more request
`include "chat_message_deframer_top_assert.svh"

module chat_message_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_field_tag,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_message,
   output logic [2:0]  rsp_status,
   output logic        rsp_address_unknown,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import cmd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_take;
   logic       advance;
   logic       has_result;
   logic       slot_free;
   res_type    par_res;
   res_type    rsp_res;

   assign advance   = in_valid_ff && (!has_result || slot_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   cmd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_byte          (in_byte_ff),
      .in_last          (in_last_ff),
      .advance          (advance),
      .has_result       (has_result),
      .result           (par_res)
   );

   cmd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .res_in    (par_res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .slot_free (slot_free),
      .res_out   (rsp_res)
   );

   assign rsp_field_tag       = rsp_res.tag;
   assign rsp_out_byte        = rsp_res.data;
   assign rsp_end_of_message  = rsp_res.eom;
   assign rsp_status          = rsp_res.status;
   assign rsp_address_unknown = rsp_res.addr_unknown;

   // a held request is never dropped
   `CMD_ASSERT_NEXT(a_held_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // a result without a byte only exists to close a message
   `CMD_ASSERT_IMP(a_empty_is_eom, clock, reset,
      rsp_valid && rsp_res.tag == TAG_NONE, rsp_res.eom)
   // status only rides on the closing result
   `CMD_ASSERT_IMP(a_status_on_eom, clock, reset,
      rsp_valid && rsp_res.status != ST_OK, rsp_res.eom)
   // unknown address only on a good closing result
   `CMD_ASSERT_IMP(a_addr_unknown_ok, clock, reset,
      rsp_valid && rsp_res.addr_unknown, rsp_res.eom && rsp_res.status == ST_OK)

endmodule

>>> tb/chat_message_deframer_checker.sv
`timescale 1ns / 1ps

module chat_message_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_field_tag,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_end_of_message,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_address_unknown,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   import cmd_pkg::*;

   logic [31:0] magic_word;
   phase_type   stage;
   logic [2:0]  bytes_seen;
   logic        magic_good;
   logic [10:0] kept;
   logic [10:0] sender_seen;
   logic        at_seen;
   logic        text_done;

   res_type     deframed_bytes [$];

   task automatic clear_parse();
      stage       = PH_MAGIC;
      bytes_seen  = '0;
      magic_good  = 1'b1;
      kept        = '0;
      sender_seen = '0;
      at_seen     = 1'b0;
      text_done   = 1'b0;
   endtask

   // sender bytes past the buffer cut are dropped and cannot split the sender
   task automatic sender_step(input logic [7:0] b, output tag_type tag);
      tag = TAG_NONE;
      if (sender_seen < BUFFER_BYTES - 1) begin
         if (!at_seen && b == CHAR_AT) begin
            at_seen = 1'b1;
            kept    = '0;
         end else if (!at_seen) begin
            if (sender_seen < NAME_LIMIT)
               tag = TAG_NAME;
         end else if (kept < ADDRESS_LIMIT) begin
            tag  = TAG_ADDR;
            kept = kept + 1'b1;
         end
         sender_seen = sender_seen + 1'b1;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic fin);
      tag_type    tag;
      status_type st;
      logic       unknown;
      res_type    r;
      tag     = TAG_NONE;
      st      = ST_OK;
      unknown = 1'b0;
      if (stage == PH_MAGIC) begin
         if (magic_word[24 - 8 * bytes_seen[1:0] +: 8] != b)
            magic_good = 1'b0;
         if (bytes_seen >= MAGIC_END)
            stage = PH_TYPE_SKIP;
      end else if (!text_done) begin
         if (b == CHAR_NUL) begin
            text_done = 1'b1;
         end else begin
            case (stage)
               PH_TYPE_SKIP: begin
                  if (b != CHAR_PIPE) begin
                     stage = PH_TYPE;
                     kept  = 11'd1;
                     tag   = TAG_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (b == CHAR_PIPE) begin
                     stage = PH_SENDER_SKIP;
                  end else if (kept < TYPE_LIMIT) begin
                     kept = kept + 1'b1;
                     tag  = TAG_TYPE;
                  end
               end
               PH_SENDER_SKIP: begin
                  if (b != CHAR_PIPE) begin
                     stage       = PH_SENDER;
                     sender_seen = '0;
                     at_seen     = 1'b0;
                     sender_step(b, tag);
                  end
               end
               PH_SENDER: begin
                  if (b == CHAR_PIPE) begin
                     stage = PH_CONTENT;
                     kept  = '0;
                  end else begin
                     sender_step(b, tag);
                  end
               end
               default: begin
                  if (kept < BUFFER_BYTES - 1) begin
                     kept = kept + 1'b1;
                     tag  = TAG_CONTENT;
                  end
               end
            endcase
         end
      end
      if (bytes_seen < HDR_FULL)
         bytes_seen = bytes_seen + 1'b1;

      if (fin) begin
         if (bytes_seen < HDR_FULL)
            st = ST_SHORT;
         else if (!magic_good)
            st = ST_MAGIC;
         else if (stage == PH_MAGIC || stage == PH_TYPE_SKIP)
            st = ST_NO_TYPE;
         else if (stage == PH_TYPE || stage == PH_SENDER_SKIP)
            st = ST_NO_SENDER;
         else
            unknown = !at_seen;
      end

      if (tag != TAG_NONE || fin) begin
         r.tag          = tag;
         r.data         = (tag == TAG_NONE) ? 8'h00 : b;
         r.eom          = fin;
         r.status       = st;
         r.addr_unknown = unknown;
         deframed_bytes.push_back(r);
      end
      if (fin)
         clear_parse();
   endtask

   always @(posedge clock) begin : watch
      res_type got;
      res_type want;
      if (reset) begin
         magic_word = '0;
         fail_count = 0;
         clear_parse();
         deframed_bytes.delete();
      end else begin
         if (csr_write_enable)
            magic_word = csr_write_data;
         // results are registered behind their request, so check before predicting
         if (rsp_valid && !rsp_stall) begin
            got.tag          = tag_type'(rsp_field_tag);
            got.data         = rsp_out_byte;
            got.eom          = rsp_end_of_message;
            got.status       = status_type'(rsp_status);
            got.addr_unknown = rsp_address_unknown;
            if (deframed_bytes.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: tag %0d byte %02h eom %0b status %0d unknown %0b",
                           got.tag, got.data, got.eom, got.status, got.addr_unknown);
               fail_count++;
            end else begin
               want = deframed_bytes.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected tag %0d byte %02h eom %0b status %0d ",
                               "unknown %0b, got tag %0d byte %02h eom %0b status %0d ",
                               "unknown %0b"},
                              want.tag, want.data, want.eom, want.status, want.addr_unknown,
                              got.tag, got.data, got.eom, got.status, got.addr_unknown);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            deframe_byte(req_data_byte, req_last_byte);
      end
      pending <= deframed_bytes.size();
   end

endmodule

>>> tb/chat_message_deframer_top_tb.sv
`timescale 1ns / 1ps

module chat_message_deframer_top_tb;
   import cmd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_field_tag;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_message;
   logic [2:0]  rsp_status;
   logic        rsp_address_unknown;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   int          fail_count;
   int          pending;

   bit          gaps_on;
   int          hold_requests;
   int          items_sent;
   logic [31:0] magic_now;
   logic [7:0]  frame [$];

   chat_message_deframer_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_field_tag       (rsp_field_tag),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_message  (rsp_end_of_message),
      .rsp_status          (rsp_status),
      .rsp_address_unknown (rsp_address_unknown),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   chat_message_deframer_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_field_tag       (rsp_field_tag),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_end_of_message  (rsp_end_of_message),
      .rsp_status          (rsp_status),
      .rsp_address_unknown (rsp_address_unknown),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin : receiver
      int holds_done;
      int hold_left;
      rsp_stall  = 1'b0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            for (hold_left = 300; hold_left > 0; hold_left--) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 25);
      end
   end

   // called and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (gaps_on && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame.size(); i++)
         send_byte(frame[i], i == frame.size() - 1);
      frame.delete();
   endtask

   // bytes that give no result may still be in flight when the queue empties
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_magic(input logic [31:0] value);
      magic_now        = value;
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] field_char(input bit specials);
      logic [7:0] c;
      if (specials && $urandom_range(0, 99) < 5) begin
         case ($urandom_range(0, 2))
            0:       return CHAR_NUL;
            1:       return CHAR_PIPE;
            default: return CHAR_AT;
         endcase
      end
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_PIPE || c == CHAR_AT);
      return c;
   endfunction

   function automatic int pick_len(input int limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 85)
         return $urandom_range(1, limit);
      return $urandom_range(limit + 1, limit + 10);
   endfunction

   task automatic push_magic();
      int i;
      for (i = 0; i < 4; i++)
         frame.push_back(magic_now[31 - 8 * i -: 8]);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         frame.push_back(s[i]);
   endtask

   task automatic push_field(input int n, input bit specials);
      repeat (n) frame.push_back(field_char(specials));
   endtask

   task automatic build_message();
      int k;
      int cut;
      frame.delete();
      if ($urandom_range(0, 99) < 8) begin
         // line noise
         repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
         push_magic();
         if ($urandom_range(0, 99) < 10) begin
            k        = $urandom_range(0, 3);
            frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
         end
         repeat ($urandom_range(0, 2)) frame.push_back(CHAR_PIPE);
         push_field(pick_len(TYPE_LIMIT), 1'b1);
         frame.push_back(CHAR_PIPE);
         repeat ($urandom_range(0, 2)) frame.push_back(CHAR_PIPE);
         push_field(pick_len(NAME_LIMIT), 1'b0);
         if ($urandom_range(0, 99) < 75) begin
            frame.push_back(CHAR_AT);
            push_field(pick_len(ADDRESS_LIMIT), 1'b1);
         end
         if ($urandom_range(0, 99) < 80) begin
            frame.push_back(CHAR_PIPE);
            repeat (pick_len(12)) frame.push_back(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 99) < 10) begin
            frame.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
         end
         // broken-off message
         if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
               frame.delete(frame.size() - 1);
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] magic_set [5];
      int          p;
      int          target;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_last_byte    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 32'h0;
      gaps_on          = 1'b1;
      hold_requests    = 0;
      items_sent       = 0;
      magic_now        = 32'h0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // magic holds a NUL, all-ones, a pipe and an at sign
      write_magic(32'h00FF_7C40);
      // too short beats bad magic
      frame.push_back(CHAR_PIPE);
      frame.push_back(8'h41);
      send_frame();
      push_magic();
      push_text("|T|n@a|");
      frame.push_back(8'hFF);
      send_frame();
      // sender ended by NUL: empty content, no address
      push_magic();
      push_text("T|n");
      frame.push_back(CHAR_NUL);
      send_frame();

      // content past the buffer cut
      push_magic();
      push_text("T|n@a|");
      repeat (BUFFER_BYTES + 80) frame.push_back(8'($urandom_range(1, 255)));
      send_frame();
      // sender past the buffer cut, with an at sign beyond it
      push_magic();
      push_text("T|");
      push_field(BUFFER_BYTES + 6, 1'b0);
      frame.push_back(CHAR_AT);
      push_text("xyz|c");
      send_frame();

      magic_set[0] = 32'h0000_0000;
      magic_set[1] = 32'hFFFF_FFFF;
      magic_set[2] = $urandom();
      magic_set[3] = 32'h7C40_7C40;
      magic_set[4] = $urandom();
      items_sent = 0;
      for (p = 0; p < 5; p++) begin
         wait_idle();
         write_magic(magic_set[p]);
         gaps_on = (p != 1);
         if (p == 2)
            hold_requests++;
         target = 350 * (p + 1);
         while (items_sent < target) begin
            build_message();
            send_frame();
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cmd_pkg.sv
rtl/cmd_parser.sv
rtl/cmd_out_reg.sv
rtl/chat_message_deframer_top.sv
tb/chat_message_deframer_checker.sv
tb/chat_message_deframer_top_tb.sv
